/* design/trs_pkg.sv */
// Shared types and constants of the telomere read scanner.
// No dependencies; every other design file refers to it by scoped name.
`default_nettype none

package trs_pkg;

  localparam int MAX_READ_LEN_DEF = 65535;
  localparam int TOTAL_WIDTH_DEF  = 48;

  localparam int BASE_W     = 8;
  localparam int HIST_W     = 40;
  localparam int HITS_W     = 14;
  localparam int CUTOFF_W   = 6;
  localparam int GC_PCT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int EST_W      = 29;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [HIST_W-1:0] FWD_PREFIX = "TTAGG";
  localparam logic [HIST_W-1:0] REV_PREFIX = "CCCTA";
  localparam logic [BASE_W-1:0] CH_A = "A";
  localparam logic [BASE_W-1:0] CH_C = "C";
  localparam logic [BASE_W-1:0] CH_G = "G";

  localparam int MOTIF_LEN = 6;
  localparam int PCT_SCALE = 100;

  // floor(both * EST_SCALE / (EST_DIV * window)) is the Q.16 estimate
  localparam int                    SCALE_BITS = 36;
  localparam int                    SB_W       = $clog2(SCALE_BITS);
  localparam logic [SCALE_BITS-1:0] EST_SCALE  = 36'd831802 << 16;
  localparam int                    EST_DIV    = 115;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GC_LOW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GC_HIGH      = 2'd2;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST  = 6'd7;
  localparam logic [GC_PCT_W-1:0] GC_LOW_RST  = 7'd48;
  localparam logic [GC_PCT_W-1:0] GC_HIGH_RST = 7'd52;

  typedef struct packed {
    logic eval_en;
    logic den_load;
    logic dbl_en;
    logic add_en;
    logic out_load;
  } trs_cmd_t;

  typedef struct packed {
    logic window_zero;
    logic out_free;
  } trs_sts_t;

endpackage

`default_nettype wire

/* design/trs_in_if.sv */
// Base channel of the telomere read scanner: one base character a beat.
// Depends on trs_pkg for field widths.
`default_nettype none

interface trs_in_if;
  logic                       valid;
  logic                       ready;
  logic [trs_pkg::BASE_W-1:0] base_char;
  logic                       last_base;
  logic                       non_primary;

  modport source (output valid, base_char, last_base, non_primary, input ready);
  modport sink   (input valid, base_char, last_base, non_primary, output ready);
endinterface

`default_nettype wire

/* design/trs_out_if.sv */
// Result channel of the telomere read scanner: one read summary a beat.
// Depends on trs_pkg for field widths and the default total width.
`default_nettype none

interface trs_out_if #(
  parameter int TOTAL_WIDTH = trs_pkg::TOTAL_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       read_used;
  logic [trs_pkg::HITS_W-1:0] motif_count;
  logic                       in_gc_window;
  logic [TOTAL_WIDTH-1:0]     telomeric_total;
  logic [TOTAL_WIDTH-1:0]     window_total;
  logic [TOTAL_WIDTH-1:0]     both_total;
  logic [trs_pkg::EST_W-1:0]  length_estimate;
  logic                       estimate_valid;

  modport source (
    output valid, read_used, motif_count, in_gc_window, telomeric_total,
           window_total, both_total, length_estimate, estimate_valid,
    input  ready
  );
  modport sink (
    input  valid, read_used, motif_count, in_gc_window, telomeric_total,
           window_total, both_total, length_estimate, estimate_valid,
    output ready
  );
endinterface

`default_nettype wire

/* design/trs_dpath.sv */
// Datapath: per-read base counters, read-end filters, running totals,
// shift-subtract estimate divider and the result register.
// Depends on trs_pkg and trs_out_if; driven by trs_ctrl commands.
`default_nettype none

module trs_dpath #(
  parameter int MAX_READ_LEN = trs_pkg::MAX_READ_LEN_DEF,
  parameter int TOTAL_WIDTH  = trs_pkg::TOTAL_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_fire,
  input  wire logic [trs_pkg::BASE_W-1:0]     base_char,
  input  wire logic                           last_base,
  input  wire logic                           non_primary,
  input  wire logic                           cfg_we,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire trs_pkg::trs_cmd_t              cmd,
  output trs_pkg::trs_sts_t                   sts,
  trs_out_if.source                           out_bus
);

  localparam int LW = $clog2(MAX_READ_LEN + 1);
  localparam int MW = LW + trs_pkg::GC_PCT_W;
  localparam int TW = TOTAL_WIDTH;
  localparam int DW = TW + 7;
  localparam int HW = trs_pkg::HITS_W;
  localparam int EW = trs_pkg::EST_W;

  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_READ_LEN);

  logic [trs_pkg::CUTOFF_W-1:0] cutoff_r, cutoff_nxt;
  logic [trs_pkg::GC_PCT_W-1:0] gc_low_r, gc_low_nxt;
  logic [trs_pkg::GC_PCT_W-1:0] gc_high_r, gc_high_nxt;

  logic [trs_pkg::HIST_W-1:0] hist_r, hist_nxt;
  logic [HW-1:0]              fwd_r, fwd_nxt;
  logic [HW-1:0]              rev_r, rev_nxt;
  logic [LW-1:0]              gc_r, gc_nxt;
  logic [LW-1:0]              len_r, len_nxt;

  logic [LW-1:0] end_len_r, end_len_nxt;
  logic [LW-1:0] end_gc_r, end_gc_nxt;
  logic [HW-1:0] end_motif_r, end_motif_nxt;
  logic          end_np_r, end_np_nxt;

  logic [TW-1:0] tel_r, tel_nxt;
  logic [TW-1:0] win_r, win_nxt;
  logic [TW-1:0] both_r, both_nxt;
  logic          used_r, used_nxt;
  logic          inwin_r, inwin_nxt;

  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [EW-1:0] quo_r, quo_nxt;

  logic                   ov_r, ov_nxt;
  logic                   o_used_r, o_used_nxt;
  logic [HW-1:0]          o_motif_r, o_motif_nxt;
  logic                   o_inwin_r, o_inwin_nxt;
  logic [TW-1:0]          o_tel_r, o_tel_nxt;
  logic [TW-1:0]          o_win_r, o_win_nxt;
  logic [TW-1:0]          o_both_r, o_both_nxt;
  logic [EW-1:0]          o_est_r, o_est_nxt;
  logic                   o_estv_r, o_estv_nxt;

  logic [HW-1:0] fwd_new, rev_new;
  logic [LW-1:0] gc_new, len_new;
  logic          is_gc;
  logic [MW-1:0] six_cut, gc100, lo_prod, hi_prod;
  logic          used_c, inwin_c, telo_c;
  logic [DW:0]   dbl_t, add_t;

  always_comb begin
    fwd_new = fwd_r;
    if (hist_r == trs_pkg::FWD_PREFIX && base_char == trs_pkg::CH_G &&
        fwd_r != trs_pkg::HITS_MAX) begin
      fwd_new = fwd_r + HW'(1);
    end
    rev_new = rev_r;
    if (hist_r == trs_pkg::REV_PREFIX && base_char == trs_pkg::CH_A &&
        rev_r != trs_pkg::HITS_MAX) begin
      rev_new = rev_r + HW'(1);
    end
    is_gc  = (base_char == trs_pkg::CH_C) || (base_char == trs_pkg::CH_G);
    gc_new = (is_gc && gc_r != LEN_MAX) ? gc_r + LW'(1) : gc_r;
    len_new = (len_r != LEN_MAX) ? len_r + LW'(1) : len_r;

    six_cut = MW'(cutoff_r) * MW'(trs_pkg::MOTIF_LEN);
    gc100   = MW'(end_gc_r) * MW'(trs_pkg::PCT_SCALE);
    lo_prod = MW'(end_len_r) * MW'(gc_low_r);
    hi_prod = MW'(end_len_r) * MW'(gc_high_r);
    used_c  = !end_np_r && (MW'(end_len_r) >= six_cut);
    inwin_c = (gc100 >= lo_prod) && (gc100 < hi_prod);
    telo_c  = end_motif_r >= HW'(cutoff_r);

    dbl_t = {rem_r, 1'b0};
    add_t = {1'b0, rem_r} + (DW + 1)'(both_r);
  end

  always_comb begin
    cutoff_nxt  = cutoff_r;
    gc_low_nxt  = gc_low_r;
    gc_high_nxt = gc_high_r;
    if (cfg_we) begin
      case (cfg_index)
        trs_pkg::CFG_MOTIF_CUTOFF: cutoff_nxt = cfg_wdata[trs_pkg::CUTOFF_W-1:0];
        trs_pkg::CFG_GC_LOW:       gc_low_nxt = cfg_wdata;
        trs_pkg::CFG_GC_HIGH:      gc_high_nxt = cfg_wdata;
        default: ;
      endcase
    end

    hist_nxt      = hist_r;
    fwd_nxt       = fwd_r;
    rev_nxt       = rev_r;
    gc_nxt        = gc_r;
    len_nxt       = len_r;
    end_len_nxt   = end_len_r;
    end_gc_nxt    = end_gc_r;
    end_motif_nxt = end_motif_r;
    end_np_nxt    = end_np_r;
    if (in_fire) begin
      if (last_base) begin
        hist_nxt      = '0;
        fwd_nxt       = '0;
        rev_nxt       = '0;
        gc_nxt        = '0;
        len_nxt       = '0;
        end_len_nxt   = len_new;
        end_gc_nxt    = gc_new;
        end_motif_nxt = (fwd_new > rev_new) ? fwd_new : rev_new;
        end_np_nxt    = non_primary;
      end else begin
        hist_nxt = {hist_r[trs_pkg::HIST_W-trs_pkg::BASE_W-1:0], base_char};
        fwd_nxt  = fwd_new;
        rev_nxt  = rev_new;
        gc_nxt   = gc_new;
        len_nxt  = len_new;
      end
    end

    tel_nxt   = tel_r;
    win_nxt   = win_r;
    both_nxt  = both_r;
    used_nxt  = used_r;
    inwin_nxt = inwin_r;
    if (cmd.eval_en) begin
      used_nxt  = used_c;
      inwin_nxt = inwin_c;
      if (used_c) begin
        if (telo_c && tel_r != '1) tel_nxt = tel_r + TW'(1);
        if (inwin_c && win_r != '1) win_nxt = win_r + TW'(1);
        if (telo_c && inwin_c && both_r != '1) both_nxt = both_r + TW'(1);
      end
    end

    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.den_load) begin
      den_nxt = DW'(win_r) * DW'(trs_pkg::EST_DIV);
      rem_nxt = '0;
      quo_nxt = '0;
    end else if (cmd.dbl_en) begin
      if (dbl_t >= {1'b0, den_r}) begin
        rem_nxt = DW'(dbl_t - {1'b0, den_r});
        quo_nxt = {quo_r[EW-2:0], 1'b1};
      end else begin
        rem_nxt = dbl_t[DW-1:0];
        quo_nxt = {quo_r[EW-2:0], 1'b0};
      end
    end else if (cmd.add_en) begin
      if (add_t >= {1'b0, den_r}) begin
        rem_nxt = DW'(add_t - {1'b0, den_r});
        quo_nxt = quo_r + EW'(1);
      end else begin
        rem_nxt = add_t[DW-1:0];
      end
    end

    ov_nxt      = ov_r;
    o_used_nxt  = o_used_r;
    o_motif_nxt = o_motif_r;
    o_inwin_nxt = o_inwin_r;
    o_tel_nxt   = o_tel_r;
    o_win_nxt   = o_win_r;
    o_both_nxt  = o_both_r;
    o_est_nxt   = o_est_r;
    o_estv_nxt  = o_estv_r;
    if (out_bus.ready) ov_nxt = 1'b0;
    if (cmd.out_load) begin
      ov_nxt      = 1'b1;
      o_used_nxt  = used_r;
      o_motif_nxt = end_motif_r;
      o_inwin_nxt = inwin_r;
      o_tel_nxt   = tel_r;
      o_win_nxt   = win_r;
      o_both_nxt  = both_r;
      o_est_nxt   = (win_r == '0) ? '0 : quo_r;
      o_estv_nxt  = (win_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= trs_pkg::CUTOFF_RST;
      gc_low_r  <= trs_pkg::GC_LOW_RST;
      gc_high_r <= trs_pkg::GC_HIGH_RST;
      hist_r    <= '0;
      fwd_r     <= '0;
      rev_r     <= '0;
      gc_r      <= '0;
      len_r     <= '0;
      tel_r     <= '0;
      win_r     <= '0;
      both_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      cutoff_r  <= cutoff_nxt;
      gc_low_r  <= gc_low_nxt;
      gc_high_r <= gc_high_nxt;
      hist_r    <= hist_nxt;
      fwd_r     <= fwd_nxt;
      rev_r     <= rev_nxt;
      gc_r      <= gc_nxt;
      len_r     <= len_nxt;
      tel_r     <= tel_nxt;
      win_r     <= win_nxt;
      both_r    <= both_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_len_r   <= end_len_nxt;
    end_gc_r    <= end_gc_nxt;
    end_motif_r <= end_motif_nxt;
    end_np_r    <= end_np_nxt;
    used_r      <= used_nxt;
    inwin_r     <= inwin_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    o_used_r    <= o_used_nxt;
    o_motif_r   <= o_motif_nxt;
    o_inwin_r   <= o_inwin_nxt;
    o_tel_r     <= o_tel_nxt;
    o_win_r     <= o_win_nxt;
    o_both_r    <= o_both_nxt;
    o_est_r     <= o_est_nxt;
    o_estv_r    <= o_estv_nxt;
  end

  assign sts.window_zero = (win_r == '0);
  assign sts.out_free    = !ov_r || out_bus.ready;

  assign out_bus.valid           = ov_r;
  assign out_bus.read_used       = o_used_r;
  assign out_bus.motif_count     = o_motif_r;
  assign out_bus.in_gc_window    = o_inwin_r;
  assign out_bus.telomeric_total = o_tel_r;
  assign out_bus.window_total    = o_win_r;
  assign out_bus.both_total      = o_both_r;
  assign out_bus.length_estimate = o_est_r;
  assign out_bus.estimate_valid  = o_estv_r;

endmodule

`default_nettype wire

/* design/trs_ctrl.sv */
// Controller: sequences the read-end work (filters and totals, divisor load,
// one quotient bit per step, result load). Depends on trs_pkg.
`default_nettype none

module trs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              end_fire,
  input  wire trs_pkg::trs_sts_t sts,
  output trs_pkg::trs_cmd_t      cmd,
  output logic                   busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DEN  = 3'd2;
  localparam logic [2:0] S_DBL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [trs_pkg::SB_W-1:0] BIT_TOP = trs_pkg::SB_W'(trs_pkg::SCALE_BITS - 1);

  logic [2:0]              st_r, st_nxt;
  logic [trs_pkg::SB_W-1:0] bit_r, bit_nxt;

  always_comb begin
    st_nxt = st_r;
    bit_nxt = bit_r;
    cmd = '0;
    case (st_r)
      S_IDLE: begin
        if (end_fire) st_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval_en = 1'b1;
        st_nxt = S_DEN;
      end
      S_DEN: begin
        cmd.den_load = 1'b1;
        bit_nxt = BIT_TOP;
        st_nxt = sts.window_zero ? S_OUT : S_DBL;
      end
      S_DBL: begin
        cmd.dbl_en = 1'b1;
        if (trs_pkg::EST_SCALE[bit_r]) begin
          st_nxt = S_ADD;
        end else if (bit_r == '0) begin
          st_nxt = S_OUT;
        end else begin
          bit_nxt = bit_r - trs_pkg::SB_W'(1);
        end
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        if (bit_r == '0) begin
          st_nxt = S_OUT;
        end else begin
          bit_nxt = bit_r - trs_pkg::SB_W'(1);
          st_nxt = S_DBL;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      bit_r <= '0;
    end else begin
      st_r  <= st_nxt;
      bit_r <= bit_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);

endmodule

`default_nettype wire

/* design/telomere_read_scanner.sv */
// Telomere read scanner top level: joins controller and datapath.
// Depends on trs_pkg, trs_in_if, trs_out_if, trs_ctrl and trs_dpath.
//
// Bases are taken one a beat, every cycle, and each read yields one result
// beat after its last base. The read-end work runs in a shift-subtract
// divider: a step for filters and totals, a step to load the divisor, a
// doubling step per bit of the 36-bit scale constant and an add step for
// each of its 10 set bits, then a step to load the result register; the
// divider steps are skipped while the GC window total is still zero.
// Bases of the following read are accepted meanwhile; only its last base
// waits until the divider is done and the result register is free.
`default_nettype none

module telomere_read_scanner #(
  parameter int MAX_READ_LEN = trs_pkg::MAX_READ_LEN_DEF,
  parameter int TOTAL_WIDTH  = trs_pkg::TOTAL_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  trs_in_if.sink                              in_bus,
  trs_out_if.source                           out_bus,
  input  wire logic                           cfg_we,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  trs_pkg::trs_cmd_t cmd;
  trs_pkg::trs_sts_t sts;
  logic              busy;
  logic              in_fire;

  // hold only a last base while the previous read is still being finished
  assign in_bus.ready = !busy || !in_bus.last_base;
  assign in_fire      = in_bus.valid && in_bus.ready;

  trs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .end_fire (in_fire && in_bus.last_base),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  trs_dpath #(
    .MAX_READ_LEN (MAX_READ_LEN),
    .TOTAL_WIDTH  (TOTAL_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .base_char   (in_bus.base_char),
    .last_base   (in_bus.last_base),
    .non_primary (in_bus.non_primary),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_bus     (out_bus)
  );

  a_both_le_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.both_total <= out_bus.window_total)
    else $error("both total exceeds window total");

  a_est_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.estimate_valid == (out_bus.window_total != '0)))
    else $error("estimate valid flag disagrees with window total");

  a_est_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.estimate_valid) |-> out_bus.length_estimate == '0)
    else $error("estimate nonzero without window reads");

  a_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.last_base) |=> busy)
    else $error("read end did not start the controller");

endmodule

`default_nettype wire

/* sim/trs_read_checker.sv */
`timescale 1ns / 100ps
// Read summary checker of the telomere read scanner bench: follows the base and
// result channels and the register port, predicts each read summary, compares.
// Depends on trs_pkg, trs_in_if and trs_out_if.

module trs_read_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  trs_in_if                              in_bus,
  trs_out_if                             out_bus,
  input  logic                           cfg_we,
  input  logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  localparam int TW = trs_pkg::TOTAL_WIDTH_DEF;
  localparam logic [39:0]   FWD_HEAD  = "TTAGG";
  localparam logic [39:0]   REV_HEAD  = "CCCTA";
  localparam logic [15:0]   LEN_CAP   = 16'hFFFF;
  localparam logic [13:0]   HIT_CAP   = 14'h3FFF;
  localparam logic [TW-1:0] TOTAL_CAP = '1;

  typedef struct packed {
    logic                      read_used;
    logic [trs_pkg::HITS_W-1:0] motif_count;
    logic                      in_gc_window;
    logic [TW-1:0]             telomeric_total;
    logic [TW-1:0]             window_total;
    logic [TW-1:0]             both_total;
    logic [trs_pkg::EST_W-1:0] length_estimate;
    logic                      estimate_valid;
  } read_summary_t;

  read_summary_t summary_q[$];

  logic [5:0]    cutoff;
  logic [6:0]    gc_low;
  logic [6:0]    gc_high;
  logic [39:0]   tail_bases;
  logic [13:0]   fwd_hits;
  logic [13:0]   rev_hits;
  logic [15:0]   gc_seen;
  logic [15:0]   bases_seen;
  logic [TW-1:0] telo_reads;
  logic [TW-1:0] window_reads;
  logic [TW-1:0] both_reads;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    if (fail_count < 100) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $time, field, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    read_summary_t seen;
    read_summary_t want;
    logic [7:0]    ch;
    logic [13:0]   motifs;
    logic          used;
    logic          inwin;
    logic          telo;
    logic [127:0]  num;
    logic [127:0]  den;
    if (!rst_n) begin
      cutoff       = 6'd7;
      gc_low       = 7'd48;
      gc_high      = 7'd52;
      tail_bases   = '0;
      fwd_hits     = '0;
      rev_hits     = '0;
      gc_seen      = '0;
      bases_seen   = '0;
      telo_reads   = '0;
      window_reads = '0;
      both_reads   = '0;
      summary_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          trs_pkg::CFG_MOTIF_CUTOFF: cutoff = cfg_wdata[5:0];
          trs_pkg::CFG_GC_LOW:       gc_low = cfg_wdata;
          trs_pkg::CFG_GC_HIGH:      gc_high = cfg_wdata;
          default: ;
        endcase
      end

      if (out_bus.valid && out_bus.ready) begin
        seen.read_used       = out_bus.read_used;
        seen.motif_count     = out_bus.motif_count;
        seen.in_gc_window    = out_bus.in_gc_window;
        seen.telomeric_total = out_bus.telomeric_total;
        seen.window_total    = out_bus.window_total;
        seen.both_total      = out_bus.both_total;
        seen.length_estimate = out_bus.length_estimate;
        seen.estimate_valid  = out_bus.estimate_valid;
        if (summary_q.size() == 0) begin
          report("unexpected summary beat, motif_count", seen.motif_count, 0);
        end else begin
          want = summary_q.pop_front();
          if (seen.read_used !== want.read_used)
            report("read_used", seen.read_used, want.read_used);
          if (seen.motif_count !== want.motif_count)
            report("motif_count", seen.motif_count, want.motif_count);
          if (seen.in_gc_window !== want.in_gc_window)
            report("in_gc_window", seen.in_gc_window, want.in_gc_window);
          if (seen.telomeric_total !== want.telomeric_total)
            report("telomeric_total", seen.telomeric_total, want.telomeric_total);
          if (seen.window_total !== want.window_total)
            report("window_total", seen.window_total, want.window_total);
          if (seen.both_total !== want.both_total)
            report("both_total", seen.both_total, want.both_total);
          if (seen.length_estimate !== want.length_estimate)
            report("length_estimate", seen.length_estimate, want.length_estimate);
          if (seen.estimate_valid !== want.estimate_valid)
            report("estimate_valid", seen.estimate_valid, want.estimate_valid);
        end
      end

      if (in_bus.valid && in_bus.ready) begin
        ch = in_bus.base_char;
        if (tail_bases == FWD_HEAD && ch == "G" && fwd_hits != HIT_CAP) fwd_hits++;
        if (tail_bases == REV_HEAD && ch == "A" && rev_hits != HIT_CAP) rev_hits++;
        if ((ch == "C" || ch == "G") && gc_seen != LEN_CAP) gc_seen++;
        if (bases_seen != LEN_CAP) bases_seen++;
        tail_bases = {tail_bases[31:0], ch};

        if (in_bus.last_base) begin
          motifs = (fwd_hits > rev_hits) ? fwd_hits : rev_hits;
          used   = !in_bus.non_primary && (32'(bases_seen) >= 32'(cutoff) * 6);
          inwin  = (32'(gc_seen) * 100 >= 32'(gc_low) * 32'(bases_seen)) &&
                   (32'(gc_seen) * 100 <  32'(gc_high) * 32'(bases_seen));
          telo   = motifs >= {8'd0, cutoff};

          if (used && telo && telo_reads != TOTAL_CAP) telo_reads++;
          if (used && inwin && window_reads != TOTAL_CAP) window_reads++;
          if (used && telo && inwin && both_reads != TOTAL_CAP) both_reads++;

          want.read_used       = used;
          want.motif_count     = motifs;
          want.in_gc_window    = inwin;
          want.telomeric_total = telo_reads;
          want.window_total    = window_reads;
          want.both_total      = both_reads;
          want.estimate_valid  = window_reads != '0;
          if (want.estimate_valid) begin
            // kilobases in Q.16: both * 332720800 * 2^16 / (window * 46000)
            num = 128'(both_reads) * 128'd332720800 * 128'd65536;
            den = 128'(window_reads) * 128'd46000;
            num = num / den;
            want.length_estimate = num[trs_pkg::EST_W-1:0];
          end else begin
            want.length_estimate = '0;
          end
          summary_q.push_back(want);

          tail_bases = '0;
          fwd_hits   = '0;
          rev_hits   = '0;
          gc_seen    = '0;
          bases_seen = '0;
        end
      end
    end
    pending = summary_q.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top of the telomere read scanner bench: clock, reset, base stimulus, result
// back-pressure, register settings and the verdict.
// Depends on trs_pkg, trs_in_if, trs_out_if, trs_read_checker and the block.

module tb_top;
  localparam int          QUIET_LIMIT = 3000;
  localparam logic [47:0] FWD_UNIT = "TTAGGG";
  localparam logic [47:0] REV_UNIT = "CCCTAA";

  typedef enum int {
    RK_FWD_REPEAT,
    RK_REV_REPEAT,
    RK_NUCLEOTIDE,
    RK_ANY_BYTE,
    RK_GC_RICH
  } read_kind_e;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [trs_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             fail_count;
  int                             pending;
  bit                             calm = 1'b0;
  int                             stall_left = 0;
  int                             quiet = 0;
  int                             cur_cutoff = 7;

  trs_in_if  in_bus ();
  trs_out_if out_bus ();

  telomere_read_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  trs_read_checker summary_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin : sink_pace
    if (calm || !rst_n) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 10);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("[telomere_read_scanner] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] any_nucleotide();
    case ($urandom_range(0, 4))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      default: return "N";
    endcase
  endfunction

  task automatic push_base(input logic [7:0] ch, input logic last, input logic np);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.base_char   <= ch;
    in_bus.last_base   <= last;
    in_bus.non_primary <= np;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_read(input read_kind_e kind, input int len, input logic np,
                           input bit mixed_flag);
    int         offset;
    logic [7:0] ch;
    offset = $urandom_range(0, 5);
    for (int k = 0; k < len; k++) begin
      case (kind)
        RK_FWD_REPEAT: ch = FWD_UNIT[47 - 8 * ((k + offset) % 6) -: 8];
        RK_REV_REPEAT: ch = REV_UNIT[47 - 8 * ((k + offset) % 6) -: 8];
        RK_NUCLEOTIDE: ch = any_nucleotide();
        RK_ANY_BYTE:   ch = 8'($urandom);
        default:       ch = ($urandom_range(0, 3) == 0) ? any_nucleotide() :
                            ($urandom_range(0, 1) ? 8'("G") : 8'("C"));
      endcase
      // break a repeat now and then
      if ((kind == RK_FWD_REPEAT || kind == RK_REV_REPEAT) && $urandom_range(0, 39) == 0)
        ch = any_nucleotide();
      push_base(ch, k == len - 1, (mixed_flag && k != len - 1) ? 1'($urandom) : np);
    end
  endtask

  task automatic random_reads(input int base_budget, input int read_floor);
    int         bases;
    int         reads;
    int         len;
    int         lo;
    read_kind_e kind;
    bases = 0;
    reads = 0;
    while (bases < base_budget || reads < read_floor) begin
      kind = read_kind_e'($urandom_range(0, 4));
      lo   = (6 * cur_cutoff > 2) ? 6 * cur_cutoff - 2 : 1;
      case ($urandom_range(0, 3))
        0:       len = $urandom_range(1, 12);
        1:       len = $urandom_range(40, 120);
        default: len = $urandom_range(lo, lo + 20);
      endcase
      send_read(kind, len, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
      bases += len;
      reads++;
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic load_settings(input int cutoff, input int low, input int high);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= trs_pkg::CFG_MOTIF_CUTOFF;
    cfg_wdata <= 7'(cutoff);
    @(negedge clk);
    cfg_index <= trs_pkg::CFG_GC_LOW;
    cfg_wdata <= 7'(low);
    @(negedge clk);
    cfg_index <= trs_pkg::CFG_GC_HIGH;
    cfg_wdata <= 7'(high);
    @(negedge clk);
    cfg_we     <= 1'b0;
    cur_cutoff = cutoff;
  endtask

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.base_char   = '0;
    in_bus.last_base   = 1'b0;
    in_bus.non_primary = 1'b0;
    out_bus.ready      = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-base reads at the byte extremes, then each motif once
    push_base(8'h00, 1'b1, 1'b0);
    push_base(8'hFF, 1'b1, 1'b1);
    for (int k = 0; k < 6; k++) push_base(FWD_UNIT[47 - 8 * k -: 8], k == 5, 1'b0);
    // flag set on early bases, cleared on the last one
    for (int k = 0; k < 6; k++) push_base(REV_UNIT[47 - 8 * k -: 8], k == 5, k != 5);
    push_base("G", 1'b0, 1'b0);
    push_base("C", 1'b1, 1'b0);
    push_base("C", 1'b0, 1'b1);
    push_base("G", 1'b0, 1'b1);
    push_base("T", 1'b0, 1'b1);
    push_base("A", 1'b1, 1'b1);
    push_base("G", 1'b1, 1'b0);

    load_settings(0, 0, 127);
    random_reads(80, 3);

    load_settings(63, 0, 100);
    random_reads(0, 1);

    load_settings(2, 100, 100);
    random_reads(60, 3);
    load_settings(5, 127, 0);
    random_reads(60, 2);
    repeat (2) begin
      load_settings($urandom_range(1, 8), $urandom_range(0, 55), $urandom_range(45, 100));
      random_reads(60, 2);
    end

    load_settings(1, 0, 100);
    calm = 1'b1;
    random_reads(60, 3);

    drain();
    if (fail_count == 0) begin
      $display("[telomere_read_scanner] OK");
    end else begin
      $display("[telomere_read_scanner] ERROR");
    end
    $finish;
  end

endmodule
